FILE: rtl/gmb_pkg.sv
// Package for the Gaussian mixture background subtractor: frame and mixture sizes,
// row layout, sequencer states, shared divider interface and the density table.
// Depends on nothing; the top module, multiplier and divider use it by scoped names.
`default_nettype none

package gmb_pkg;

    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 256;
    localparam int COMPONENTS   = 3;

    localparam int COMP_W   = $clog2(COMPONENTS);
    localparam int PIXELS   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W   = $clog2(PIXELS);
    localparam int SUM_W    = 16 + $clog2(COMPONENTS + 1);
    localparam int PROD_W   = 49;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 17;

    localparam int TABLE_SIZE = 1000;
    localparam int TABLE_W    = $clog2(TABLE_SIZE);

    localparam logic [15:0] NEW_WEIGHT      = 16'd66;
    localparam logic [15:0] DEV_FLOOR       = 16'd128;
    localparam logic [15:0] RESET_ALPHA     = 16'd655;
    localparam logic [15:0] RESET_PORTION   = 16'd45875;
    localparam logic [15:0] RESET_DEVIATION = 16'd5120;
    localparam logic [7:0]  RESET_THRESHOLD = 8'd40;
    localparam logic [63:0] PHI0_Q30        = 64'd428361012;

    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE,
        CFG_BACKGROUND_PORTION,
        CFG_INITIAL_DEVIATION,
        CFG_MATCH_THRESHOLD
    } t_cfg_index;

    // One memory row holds the whole mixture of one pixel.
    typedef struct packed {
        logic [COMPONENTS-1:0][15:0]       weight;
        logic [COMPONENTS-1:0][15:0]       mean;
        logic [COMPONENTS-1:0][15:0]       deviation;
        logic [COMPONENTS-1:0][COMP_W-1:0] rank;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } t_ds_mode;

    typedef struct packed {
        logic        start;
        t_ds_mode    mode;
        logic [33:0] num;
        logic [23:0] den;
    } t_ds_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_ds_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MATCH,
        S_MATCH_CMP,
        S_DECAY,
        S_DECAY_ACC,
        S_NORM,
        S_NORM_WAIT,
        S_BUBBLE,
        S_YMUL,
        S_YDIV,
        S_YWAIT,
        S_ROM,
        S_RDIV,
        S_RWAIT,
        S_MEAN1,
        S_MEAN2,
        S_MEAN3,
        S_DEV1,
        S_DEV2,
        S_DEV3,
        S_DEV4,
        S_DEV5,
        S_DEV6,
        S_WB,
        S_DONE
    } t_state;

    function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Sample of 65536 * phi(i / 250) built from a truncated series and ten squarings,
    // with 64-bit wrapping arithmetic throughout.
    function automatic logic [15:0] density_entry(input logic [63:0] i);
        logic [63:0] v;
        logic [63:0] v2;
        logic [63:0] v3;
        logic [63:0] v4;
        logic [63:0] e;
        v  = ((i * i) << 20) / 64'd125000;
        v2 = (v * v) >> 30;
        v3 = (v2 * v) >> 30;
        v4 = (v3 * v) >> 30;
        e  = (64'd1 << 30) + v2 / 64'd2 + v4 / 64'd24 - v - v3 / 64'd6;
        for (int n = 0; n < 10; n++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        e = (e * PHI0_Q30 + (64'd1 << 43)) >> 44;
        return (e > 64'd65535) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic logic [TABLE_SIZE-1:0][15:0] build_density_table();
        logic [TABLE_SIZE-1:0][15:0] t;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            t[i] = density_entry(64'(i));
        end
        return t;
    endfunction

    localparam logic [TABLE_SIZE-1:0][15:0] DENSITY_TABLE = build_density_table();

    function automatic t_row reset_row();
        t_row r;
        for (int k = 0; k < COMPONENTS; k++) begin
            r.weight[k]    = '0;
            r.mean[k]      = '0;
            r.deviation[k] = RESET_DEVIATION;
            r.rank[k]      = COMP_W'(k);
        end
        return r;
    endfunction

    localparam t_row RESET_ROW = reset_row();

endpackage

`default_nettype wire

FILE: rtl/gaussian_mixture_background_subtract.sv
// Gaussian mixture background subtractor, one gray pixel per transaction.
// Three normalizing divisions (only when the weight sum is nonzero), up to two table
// divisions and the square root all run in the shared iterative unit. A stalled result
// holds the block in its done state until the output is free.
// One pixel at a time: no new input is taken until the result of the last is registered.
// Reset: synchronous, active low; afterwards a clearing pass writes the reset mixture
// to every pixel row, and no input transaction is taken meanwhile.
`default_nettype none

module gaussian_mixture_background_subtract (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_pixel_x,
    input  wire logic [7:0]                     i_pixel_y,
    input  wire logic [7:0]                     i_pixel_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_out_x,
    output logic [7:0]                          o_out_y,
    output logic                                o_is_foreground,
    input  wire logic                           i_cfg_we,
    input  wire logic [gmb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);

    localparam int K = gmb_pkg::COMPONENTS;
    localparam int CW = gmb_pkg::COMP_W;

    // Configuration registers.
    logic [15:0] r_alpha;
    logic [15:0] r_portion;
    logic [15:0] r_init_dev;
    logic [7:0]  r_threshold;

    // Sequencer and working registers.
    gmb_pkg::t_state r_state;
    gmb_pkg::t_state n_state;
    gmb_pkg::t_row   r_row;
    logic [gmb_pkg::ADDR_W-1:0] r_addr;
    logic [gmb_pkg::ADDR_W-1:0] r_clr;
    logic [7:0]                 r_px;
    logic [7:0]                 r_py;
    logic [15:0]                r_xv;
    logic [CW-1:0]              r_pos;
    logic [CW-1:0]              r_comp;
    logic [CW-1:0]              r_k;
    logic [gmb_pkg::SUM_W-1:0]  r_sum;
    logic [16:0]                r_rho;
    logic [gmb_pkg::PROD_W-1:0] r_acc;
    logic [31:0]                r_dsq;
    logic [31:0]                r_esq;
    logic [15:0]                r_e;
    logic [15:0]                r_dens;
    logic                       r_fg;
    logic                       r_out_valid;
    logic [7:0]                 r_out_x;
    logic [7:0]                 r_out_y;
    logic                       r_out_fg;

    // Shared units.
    logic [gmb_pkg::MUL_A_W-1:0] mul_a;
    logic [gmb_pkg::MUL_B_W-1:0] mul_b;
    logic [gmb_pkg::PROD_W-1:0]  prod;
    gmb_pkg::t_ds_req            ds_req;
    gmb_pkg::t_ds_rsp            ds_rsp;

    // Row memory port signals.
    logic                        ram_we;
    logic [gmb_pkg::ADDR_W-1:0]  ram_waddr;
    gmb_pkg::t_row               ram_wdata;
    logic [gmb_pkg::ADDR_W-1:0]  ram_raddr;
    gmb_pkg::t_row               ram_rdata;

    // Combinational helpers.
    logic                        in_accept;
    logic                        out_of_frame;
    logic [CW-1:0]               cur_c;
    logic [15:0]                 match_absd;
    logic                        match_hit;
    logic [15:0]                 hit_absd;
    logic [15:0]                 hit_s;
    logic [16:0]                 one_minus_rho;
    logic [32:0]                 dec_round;
    logic [17:0]                 dec_raw;
    logic [15:0]                 dec_nw;
    logic [gmb_pkg::SUM_W-1:0]   dec_sum;
    logic [CW-1:0]               above_c;
    logic                        bubble_up;
    logic [33:0]                 mean_sum;
    logic [15:0]                 mean_new;
    logic [49:0]                 dev_sum;
    logic [gmb_pkg::SUM_W-1:0]   fg_sum;
    logic                        out_free;

    gmb_row_ram #(
        .DATA_W (gmb_pkg::ROW_W),
        .ADDR_W (gmb_pkg::ADDR_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gmb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    gmb_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .o_rsp   (ds_rsp)
    );

    // The density table is a ROM read through a register.
    always_ff @(posedge i_clk) begin
        if (r_state == gmb_pkg::S_YWAIT && ds_rsp.done &&
            ds_rsp.result < 32'(gmb_pkg::TABLE_SIZE)) begin
            r_dens <= gmb_pkg::DENSITY_TABLE[ds_rsp.result[gmb_pkg::TABLE_W-1:0]];
        end
    end

    // Configuration writes are taken in any state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= gmb_pkg::RESET_ALPHA;
            r_portion   <= gmb_pkg::RESET_PORTION;
            r_init_dev  <= gmb_pkg::RESET_DEVIATION;
            r_threshold <= gmb_pkg::RESET_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (gmb_pkg::t_cfg_index'(i_cfg_index))
                gmb_pkg::CFG_LEARNING_RATE:      r_alpha     <= i_cfg_data;
                gmb_pkg::CFG_BACKGROUND_PORTION: r_portion   <= i_cfg_data;
                gmb_pkg::CFG_INITIAL_DEVIATION:  r_init_dev  <= i_cfg_data;
                gmb_pkg::CFG_MATCH_THRESHOLD:    r_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_of_frame = (int'(i_pixel_x) >= gmb_pkg::FRAME_WIDTH) ||
                          (int'(i_pixel_y) >= gmb_pkg::FRAME_HEIGHT);
    assign out_free     = !r_out_valid || !i_out_stall;

    // Datapath helpers shared by several sequencer steps.
    always_comb begin
        cur_c      = r_row.rank[r_pos];
        match_absd = gmb_pkg::absdiff16(r_xv, r_row.mean[cur_c]);
        // The match test is exact: |x - mean| * 16 against threshold * deviation.
        match_hit  = gmb_pkg::PROD_W'({match_absd, 4'b0000}) <= prod;

        hit_absd = gmb_pkg::absdiff16(r_xv, r_row.mean[r_comp]);
        hit_s    = (r_row.deviation[r_comp] > gmb_pkg::DEV_FLOOR) ?
                   r_row.deviation[r_comp] : gmb_pkg::DEV_FLOOR;
        one_minus_rho = 17'h10000 - r_rho;

        // Weight decay with rounding; the matched component gains alpha.
        dec_round = prod[32:0] + 33'd32768;
        dec_raw   = {1'b0, dec_round[32:16]} + ((r_k == r_comp) ? {2'b00, r_alpha} : 18'd0);
        dec_nw    = (dec_raw > 18'd65535) ? 16'hFFFF : dec_raw[15:0];
        dec_sum   = r_sum + gmb_pkg::SUM_W'(dec_nw);

        above_c   = r_row.rank[r_pos - CW'(1)];
        bubble_up = (r_pos != '0) && (r_row.weight[r_comp] > r_row.weight[above_c]);

        mean_sum = {1'b0, r_acc[32:0]} + {1'b0, prod[32:0]} + 34'd32768;
        mean_new = (mean_sum[33:16] > 18'd65535) ? 16'hFFFF : mean_sum[31:16];

        dev_sum = {1'b0, r_acc} + {1'b0, prod};

        // Weight share of the components ranked above the matched one.
        fg_sum = '0;
        for (int k = 0; k < K; k++) begin
            if (k < int'(r_pos)) begin
                fg_sum = fg_sum + gmb_pkg::SUM_W'(r_row.weight[r_row.rank[k]]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmb_pkg::S_CLEAR: begin
                if (r_clr == gmb_pkg::ADDR_W'(gmb_pkg::PIXELS - 1)) begin
                    n_state = gmb_pkg::S_IDLE;
                end
            end
            gmb_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = out_of_frame ? gmb_pkg::S_DONE : gmb_pkg::S_READ;
                end
            end
            gmb_pkg::S_READ:      n_state = gmb_pkg::S_MATCH;
            gmb_pkg::S_MATCH:     n_state = gmb_pkg::S_MATCH_CMP;
            gmb_pkg::S_MATCH_CMP: begin
                if (match_hit || int'(r_pos) == K - 1) begin
                    n_state = gmb_pkg::S_DECAY;
                end else begin
                    n_state = gmb_pkg::S_MATCH;
                end
            end
            gmb_pkg::S_DECAY:     n_state = gmb_pkg::S_DECAY_ACC;
            gmb_pkg::S_DECAY_ACC: begin
                if (int'(r_k) == K - 1) begin
                    n_state = (dec_sum != '0) ? gmb_pkg::S_NORM : gmb_pkg::S_BUBBLE;
                end else begin
                    n_state = gmb_pkg::S_DECAY;
                end
            end
            gmb_pkg::S_NORM:      n_state = gmb_pkg::S_NORM_WAIT;
            gmb_pkg::S_NORM_WAIT: begin
                if (ds_rsp.done) begin
                    n_state = (int'(r_k) == K - 1) ? gmb_pkg::S_BUBBLE : gmb_pkg::S_NORM;
                end
            end
            gmb_pkg::S_BUBBLE: begin
                if (!bubble_up) begin
                    n_state = gmb_pkg::S_YMUL;
                end
            end
            gmb_pkg::S_YMUL:  n_state = gmb_pkg::S_YDIV;
            gmb_pkg::S_YDIV:  n_state = gmb_pkg::S_YWAIT;
            gmb_pkg::S_YWAIT: begin
                if (ds_rsp.done) begin
                    n_state = (ds_rsp.result < 32'(gmb_pkg::TABLE_SIZE)) ?
                              gmb_pkg::S_ROM : gmb_pkg::S_MEAN1;
                end
            end
            gmb_pkg::S_ROM:   n_state = gmb_pkg::S_RDIV;
            gmb_pkg::S_RDIV:  n_state = gmb_pkg::S_RWAIT;
            gmb_pkg::S_RWAIT: begin
                if (ds_rsp.done) begin
                    n_state = gmb_pkg::S_MEAN1;
                end
            end
            gmb_pkg::S_MEAN1: n_state = gmb_pkg::S_MEAN2;
            gmb_pkg::S_MEAN2: n_state = gmb_pkg::S_MEAN3;
            gmb_pkg::S_MEAN3: n_state = gmb_pkg::S_DEV1;
            gmb_pkg::S_DEV1:  n_state = gmb_pkg::S_DEV2;
            gmb_pkg::S_DEV2:  n_state = gmb_pkg::S_DEV3;
            gmb_pkg::S_DEV3:  n_state = gmb_pkg::S_DEV4;
            gmb_pkg::S_DEV4:  n_state = gmb_pkg::S_DEV5;
            gmb_pkg::S_DEV5:  n_state = gmb_pkg::S_DEV6;
            gmb_pkg::S_DEV6: begin
                if (ds_rsp.done) begin
                    n_state = gmb_pkg::S_WB;
                end
            end
            gmb_pkg::S_WB:    n_state = gmb_pkg::S_DONE;
            gmb_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = gmb_pkg::S_IDLE;
                end
            end
            default: n_state = gmb_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: shared unit operands, divider requests, memory ports.
    always_comb begin
        o_in_stall = (r_state != gmb_pkg::S_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        ds_req     = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = r_row;
        ram_raddr  = gmb_pkg::ADDR_W'(int'(i_pixel_y) * gmb_pkg::FRAME_WIDTH +
                                      int'(i_pixel_x));
        unique case (r_state)
            gmb_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = gmb_pkg::RESET_ROW;
            end
            gmb_pkg::S_MATCH: begin
                mul_a = 32'(r_row.deviation[cur_c]);
                mul_b = 17'(r_threshold);
            end
            gmb_pkg::S_DECAY: begin
                mul_a = 32'(r_row.weight[r_k]);
                mul_b = 17'h10000 - {1'b0, r_alpha};
            end
            gmb_pkg::S_NORM: begin
                ds_req.start = 1'b1;
                ds_req.mode  = gmb_pkg::DS_DIV;
                ds_req.num   = {2'b00, r_row.weight[r_k], 16'h0000};
                ds_req.den   = 24'(r_sum);
            end
            gmb_pkg::S_YMUL: begin
                mul_a = 32'(hit_absd);
                mul_b = 17'd500;
            end
            gmb_pkg::S_YDIV: begin
                ds_req.start = 1'b1;
                ds_req.mode  = gmb_pkg::DS_DIV;
                ds_req.num   = {2'b00, prod[31:0] + 32'(hit_s)};
                ds_req.den   = {7'b0, hit_s, 1'b0};
            end
            gmb_pkg::S_ROM: begin
                mul_a = 32'(r_dens);
                mul_b = {1'b0, r_alpha};
            end
            gmb_pkg::S_RDIV: begin
                ds_req.start = 1'b1;
                ds_req.mode  = gmb_pkg::DS_DIV;
                ds_req.num   = {2'b00, prod[31:0]};
                ds_req.den   = {hit_s, 8'h00};
            end
            gmb_pkg::S_MEAN1: begin
                mul_a = 32'(r_row.mean[r_comp]);
                mul_b = one_minus_rho;
            end
            gmb_pkg::S_MEAN2: begin
                mul_a = 32'(r_xv);
                mul_b = r_rho;
            end
            gmb_pkg::S_DEV1: begin
                mul_a = 32'(r_row.deviation[r_comp]);
                mul_b = 17'(r_row.deviation[r_comp]);
            end
            gmb_pkg::S_DEV2: begin
                mul_a = 32'(r_e);
                mul_b = 17'(r_e);
            end
            gmb_pkg::S_DEV3: begin
                mul_a = r_dsq;
                mul_b = one_minus_rho;
            end
            gmb_pkg::S_DEV4: begin
                mul_a = r_esq;
                mul_b = r_rho;
            end
            gmb_pkg::S_DEV5: begin
                ds_req.start = 1'b1;
                ds_req.mode  = gmb_pkg::DS_SQRT;
                ds_req.num   = dev_sum[49:16];
            end
            gmb_pkg::S_WB: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == gmb_pkg::S_CLEAR) begin
                r_clr <= r_clr + gmb_pkg::ADDR_W'(1);
            end
            if (r_state == gmb_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of one pixel transaction.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            gmb_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_px   <= i_pixel_x;
                    r_py   <= i_pixel_y;
                    r_xv   <= {i_pixel_value, 8'h00};
                    r_addr <= ram_raddr;
                    r_fg   <= 1'b0;
                end
            end
            gmb_pkg::S_READ: begin
                r_row <= ram_rdata;
                r_pos <= '0;
            end
            gmb_pkg::S_MATCH_CMP: begin
                r_k   <= '0;
                r_sum <= '0;
                if (match_hit) begin
                    r_comp <= cur_c;
                end else if (int'(r_pos) == K - 1) begin
                    // No component matched: replace the lowest-ranked one.
                    r_comp                  <= cur_c;
                    r_row.weight[cur_c]     <= gmb_pkg::NEW_WEIGHT;
                    r_row.mean[cur_c]       <= r_xv;
                    r_row.deviation[cur_c]  <= r_init_dev;
                end else begin
                    r_pos <= r_pos + CW'(1);
                end
            end
            gmb_pkg::S_DECAY_ACC: begin
                r_row.weight[r_k] <= dec_nw;
                r_sum             <= dec_sum;
                r_k               <= (int'(r_k) == K - 1) ? '0 : r_k + CW'(1);
            end
            gmb_pkg::S_NORM_WAIT: begin
                if (ds_rsp.done) begin
                    r_row.weight[r_k] <= (ds_rsp.result > 32'd65535) ? 16'hFFFF :
                                         ds_rsp.result[15:0];
                    r_k               <= r_k + CW'(1);
                end
            end
            gmb_pkg::S_BUBBLE: begin
                if (bubble_up) begin
                    r_row.rank[r_pos]          <= above_c;
                    r_row.rank[r_pos - CW'(1)] <= r_comp;
                    r_pos                      <= r_pos - CW'(1);
                end
            end
            gmb_pkg::S_YWAIT: begin
                if (ds_rsp.done) begin
                    r_rho <= '0;
                end
            end
            gmb_pkg::S_RWAIT: begin
                if (ds_rsp.done) begin
                    r_rho <= (ds_rsp.result > 32'h10000) ? 17'h10000 : ds_rsp.result[16:0];
                end
            end
            gmb_pkg::S_MEAN2: begin
                r_acc <= prod;
            end
            gmb_pkg::S_MEAN3: begin
                r_row.mean[r_comp] <= mean_new;
                r_e                <= gmb_pkg::absdiff16(r_xv, mean_new);
            end
            gmb_pkg::S_DEV2: begin
                r_dsq <= prod[31:0];
            end
            gmb_pkg::S_DEV3: begin
                r_esq <= prod[31:0];
            end
            gmb_pkg::S_DEV4: begin
                r_acc <= prod;
            end
            gmb_pkg::S_DEV6: begin
                if (ds_rsp.done) begin
                    r_row.deviation[r_comp] <= (ds_rsp.result > 32'd65535) ? 16'hFFFF :
                                               ds_rsp.result[15:0];
                end
            end
            gmb_pkg::S_WB: begin
                r_fg <= (fg_sum > gmb_pkg::SUM_W'(r_portion));
            end
            gmb_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_x  <= r_px;
                    r_out_y  <= r_py;
                    r_out_fg <= r_fg;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_is_foreground = r_out_fg;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == gmb_pkg::S_READ || r_state == gmb_pkg::S_DONE))
        else $error("accepted pixel did not start a transaction");
    a_bubble_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmb_pkg::S_BUBBLE) |-> (int'(r_pos) < K))
        else $error("rank position out of range");
    a_rho_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmb_pkg::S_MEAN1) |-> (r_rho <= 17'h10000))
        else $error("rho above one");
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmb_pkg::S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

endmodule

`default_nettype wire

FILE: rtl/gmb_row_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
// Holds one mixture row per pixel; generic, no package dependency.
`default_nettype none

module gmb_row_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/gmb_mul.sv
// Shared unsigned multiplier with a registered product, one result per cycle.
// Depends on gmb_pkg for the operand and product widths.
`default_nettype none

module gmb_mul (
    input  wire logic                         i_clk,
    input  wire logic [gmb_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic [gmb_pkg::MUL_B_W-1:0]  i_b,
    output logic      [gmb_pkg::PROD_W-1:0]   o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= gmb_pkg::PROD_W'(i_a) * gmb_pkg::PROD_W'(i_b);
    end

endmodule

`default_nettype wire

FILE: rtl/gmb_divsqrt.sv
// Iterative unit for restoring division (one quotient bit a cycle) and integer square
// root (one root bit a cycle); both share one compare-and-subtract. Uses gmb_pkg.
`default_nettype none

module gmb_divsqrt (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gmb_pkg::t_ds_req i_req,
    output gmb_pkg::t_ds_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    gmb_pkg::t_ds_mode r_mode;
    logic [4:0]        r_cnt;
    logic [25:0]       r_rem;
    logic [31:0]       r_q;
    logic [33:0]       r_src;
    logic [23:0]       r_den;

    logic [25:0] lhs;
    logic [25:0] rhs;
    logic [26:0] diff;
    logic        ge;

    always_comb begin
        unique case (r_mode)
            gmb_pkg::DS_DIV: begin
                lhs = {r_rem[24:0], r_src[33]};
                rhs = {2'b00, r_den};
            end
            gmb_pkg::DS_SQRT: begin
                lhs = {r_rem[23:0], r_src[33:32]};
                rhs = {r_q[23:0], 2'b01};
            end
            default: begin
                lhs = '0;
                rhs = '0;
            end
        endcase
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = ~diff[26];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_cnt  <= (i_req.mode == gmb_pkg::DS_DIV) ? 5'd31 : 5'd16;
                r_rem  <= '0;
                r_q    <= '0;
                r_src  <= (i_req.mode == gmb_pkg::DS_DIV) ? {i_req.num[31:0], 2'b00}
                                                          : i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[25:0] : lhs;
                r_q   <= {r_q[30:0], ge};
                r_src <= (r_mode == gmb_pkg::DS_DIV) ? {r_src[32:0], 1'b0}
                                                     : {r_src[31:0], 2'b00};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divsqrt started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy)) else $error("divsqrt done without run");
    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_mode == gmb_pkg::DS_SQRT) |-> (r_cnt < 5'd17))
        else $error("square root step count out of range");

endmodule

`default_nettype wire
